// ----- hdl/integer_to_base_q_digits_defines.svh -----
// Assertion macros for the radix conversion block.
// Used by the top level; needs clk and rst_n in scope.
`ifndef INTEGER_TO_BASE_Q_DIGITS_DEFINES_SVH
`define INTEGER_TO_BASE_Q_DIGITS_DEFINES_SVH

// checked only out of reset
`define IBQ_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define IBQ_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hdl/ibq_pkg.sv -----
// Shared constants, types and functions for the radix conversion block.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ibq_pkg;

    localparam int VALUE_BITS  = 63;
    localparam int MAX_DIGITS  = 64;
    localparam int RESULT_CAP  = 63;
    localparam int DIGIT_LIMIT = (MAX_DIGITS < RESULT_CAP) ? MAX_DIGITS : RESULT_CAP;

    localparam int RADIX_W = 6;
    localparam int CHAR_W  = 7;
    localparam int ADDR_W  = $clog2(MAX_DIGITS);
    localparam int CNT_W   = $clog2(DIGIT_LIMIT + 1);

    localparam logic [RADIX_W-1:0] RADIX_RESET = RADIX_W'(10);
    localparam logic [RADIX_W-1:0] RADIX_MIN   = RADIX_W'(2);
    localparam logic [RADIX_W-1:0] RADIX_MAX   = RADIX_W'(36);

    localparam logic [CHAR_W-1:0] CHAR_ZERO   = CHAR_W'(48);
    localparam logic [CHAR_W-1:0] CHAR_LETTER = CHAR_W'(55);   // 'A' minus ten
    localparam logic [RADIX_W-1:0] DEC_DIGITS = RADIX_W'(10);

    typedef struct packed {
        logic                  start;
        logic [VALUE_BITS-1:0] dividend;
        logic [RADIX_W-1:0]    divisor;
    } div_req_t;

    typedef struct packed {
        logic                  done;
        logic [VALUE_BITS-1:0] quotient;
        logic [RADIX_W-1:0]    remainder;
    } div_rsp_t;

    function automatic logic [RADIX_W-1:0] eff_radix(input logic [RADIX_W-1:0] r);
        logic [RADIX_W-1:0] res;
        res = r;
        if (r < RADIX_MIN) res = RADIX_MIN;
        if (r > RADIX_MAX) res = RADIX_MAX;
        return res;
    endfunction

    function automatic logic [CHAR_W-1:0] to_char(input logic [RADIX_W-1:0] d);
        logic [CHAR_W-1:0] ext;
        ext = {{(CHAR_W - RADIX_W){1'b0}}, d};
        return (d < DEC_DIGITS) ? (CHAR_ZERO + ext) : (CHAR_LETTER + ext);
    endfunction

endpackage

`default_nettype wire

// ----- hdl/ibq_if.sv -----
// Valid/ready channels for the input number and the output digit words.
// Depends on ibq_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface ibq_in_if;
    logic                          valid;
    logic                          ready;
    logic [ibq_pkg::VALUE_BITS-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

interface ibq_out_if;
    logic                       valid;
    logic                       ready;
    logic [ibq_pkg::CHAR_W-1:0] digit_char;
    logic                       last_digit;

    modport source (output valid, output digit_char, output last_digit, input ready);
    modport sink   (input valid, input digit_char, input last_digit, output ready);
endinterface

`default_nettype wire

// ----- hdl/ibq_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module ibq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ----- hdl/ibq_div.sv -----
// Restoring shift-subtract divider, one quotient bit per cycle.
// Depends on ibq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ibq_div (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire ibq_pkg::div_req_t req,
    output ibq_pkg::div_rsp_t      rsp
);

    localparam int STEP_W = $clog2(ibq_pkg::VALUE_BITS);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(ibq_pkg::VALUE_BITS - 1);

    logic                              busy_reg;
    logic                              done_reg;
    logic [STEP_W-1:0]                 step_reg;
    logic [ibq_pkg::VALUE_BITS-1:0]    quot_reg;
    logic [ibq_pkg::RADIX_W-1:0]       rem_reg;
    logic [ibq_pkg::RADIX_W-1:0]       div_reg;

    logic [ibq_pkg::RADIX_W:0]         trial;
    logic                              fits;
    logic [ibq_pkg::RADIX_W:0]         diff;
    logic [ibq_pkg::RADIX_W-1:0]       rem_next;

    always_comb
    begin
        trial    = {rem_reg, quot_reg[ibq_pkg::VALUE_BITS-1]};
        fits     = trial >= {1'b0, div_reg};
        diff     = trial - {1'b0, div_reg};
        rem_next = fits ? diff[ibq_pkg::RADIX_W-1:0] : trial[ibq_pkg::RADIX_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (req.start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (busy_reg)
        begin
            step_reg <= step_reg + STEP_W'(1);
            if (step_reg == LAST_STEP)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            quot_reg <= req.dividend;
            rem_reg  <= '0;
            div_reg  <= req.divisor;
        end
        else if (busy_reg)
        begin
            quot_reg <= {quot_reg[ibq_pkg::VALUE_BITS-2:0], fits};
            rem_reg  <= rem_next;
        end
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = quot_reg;
    assign rsp.remainder = rem_reg;

endmodule

`default_nettype wire

// ----- hdl/integer_to_base_q_digits.sv -----
// Top level: converts a 63-bit unsigned number to ASCII digits in base 2..36.
// Depends on ibq_pkg, ibq_if, ibq_ram, ibq_div and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "integer_to_base_q_digits_defines.svh"

// A number taken on the number channel is divided by the radix over and over by one
// shared bit-serial divider; each remainder goes into a 64-entry digit RAM, and the digits
// are then played out most significant first, the least significant one flagged with
// last_digit. Zero gives the single digit '0'. Radix values below 2 act as 2, above 36
// as 36; at most 63 digits are formed and higher ones are dropped. For each digit a start is
// issued, the divider loads and produces 63 quotient bits; once all digits are stored, each
// is read back from the RAM and presented (S_RD, S_LD, S_OUT), waiting in S_OUT while the
// output stalls. The number channel is ready only when the previous number's digits are all
// gone. radix is written through cfg_we/cfg_wdata and resets to 10.
module integer_to_base_q_digits (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    ibq_in_if.sink                            number,
    ibq_out_if.source                         digits,
    input  wire logic                         cfg_we,
    input  wire logic [ibq_pkg::RADIX_W-1:0]  cfg_wdata
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_RD,
        S_LD,
        S_OUT
    } state_t;

    localparam logic [ibq_pkg::CNT_W:0] LIMIT = (ibq_pkg::CNT_W + 1)'(ibq_pkg::DIGIT_LIMIT);

    state_t                            state_reg;
    logic [ibq_pkg::RADIX_W-1:0]       radix_reg;
    logic [ibq_pkg::VALUE_BITS-1:0]    quot_reg;
    logic [ibq_pkg::CNT_W-1:0]         count_reg;
    logic [ibq_pkg::ADDR_W-1:0]        idx_reg;
    logic                              start_reg;
    logic                              out_valid_reg;
    logic [ibq_pkg::CHAR_W-1:0]        out_char_reg;
    logic                              out_last_reg;

    ibq_pkg::div_req_t                 div_req;
    ibq_pkg::div_rsp_t                 div_rsp;

    logic                              wr_en;
    logic [ibq_pkg::RADIX_W-1:0]       rd_data;
    logic [ibq_pkg::CNT_W:0]           count_inc;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radix_reg <= ibq_pkg::RADIX_RESET;
        end
        else if (cfg_we)
        begin
            radix_reg <= cfg_wdata;
        end
    end

    assign div_req.start    = start_reg;
    assign div_req.dividend = quot_reg;
    assign div_req.divisor  = ibq_pkg::eff_radix(radix_reg);

    ibq_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign wr_en     = (state_reg == S_DIV) && div_rsp.done;
    assign count_inc = {1'b0, count_reg} + (ibq_pkg::CNT_W + 1)'(1);

    ibq_ram #(
        .WIDTH (ibq_pkg::RADIX_W),
        .DEPTH (ibq_pkg::MAX_DIGITS)
    ) u_store (
        .clk   (clk),
        .we    (wr_en),
        .waddr (count_reg[ibq_pkg::ADDR_W-1:0]),
        .wdata (div_rsp.remainder),
        .raddr (idx_reg),
        .rdata (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            quot_reg      <= '0;
            count_reg     <= '0;
            idx_reg       <= '0;
            start_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            out_char_reg  <= '0;
            out_last_reg  <= 1'b0;
        end
        else
        begin
            start_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (number.valid)
                    begin
                        quot_reg  <= number.value;
                        count_reg <= '0;
                        start_reg <= 1'b1;
                        state_reg <= S_DIV;
                    end
                end
                S_DIV:
                begin
                    if (div_rsp.done)
                    begin
                        quot_reg  <= div_rsp.quotient;
                        count_reg <= count_inc[ibq_pkg::CNT_W-1:0];
                        if ((div_rsp.quotient != '0) && (count_inc < LIMIT))
                        begin
                            start_reg <= 1'b1;
                        end
                        else
                        begin
                            // count_reg is the top digit index here
                            idx_reg   <= count_reg[ibq_pkg::ADDR_W-1:0];
                            state_reg <= S_RD;
                        end
                    end
                end
                S_RD:
                begin
                    state_reg <= S_LD;
                end
                S_LD:
                begin
                    out_char_reg  <= ibq_pkg::to_char(rd_data);
                    out_last_reg  <= (idx_reg == '0);
                    out_valid_reg <= 1'b1;
                    state_reg     <= S_OUT;
                end
                S_OUT:
                begin
                    if (digits.ready)
                    begin
                        out_valid_reg <= 1'b0;
                        if (idx_reg == '0)
                        begin
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            idx_reg   <= idx_reg - ibq_pkg::ADDR_W'(1);
                            state_reg <= S_RD;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign number.ready      = (state_reg == S_IDLE);
    assign digits.valid      = out_valid_reg;
    assign digits.digit_char = out_char_reg;
    assign digits.last_digit = out_last_reg;

    `IBQ_ASSERT_ALWAYS(a_one_side_busy, !rst_n || !(number.ready && digits.valid), "input ready while a digit is pending")
    `IBQ_ASSERT(a_last_frees_input, (digits.valid && digits.ready && digits.last_digit) |=> number.ready, "input not freed after last digit")
    `IBQ_ASSERT(a_store_in_range, wr_en |-> ({1'b0, count_reg} < LIMIT), "digit store written past the digit limit")
    `IBQ_ASSERT(a_done_in_div, div_rsp.done |-> (state_reg == S_DIV), "divider finished outside the division phase")

endmodule

`default_nettype wire

// ----- verif/tb_top.sv -----
`timescale 1ns / 1ps
// Testbench for integer_to_base_q_digits: numbers are sent under many radix settings and every
// digit word is checked against a repeated-division predictor held in a small scoreboard.
// Depends on ibq_pkg, ibq_if and the block's RTL.
module tb_top;
    import ibq_pkg::*;

    localparam int HOLD_CYCLES = 600;

    typedef struct packed {
        logic [CHAR_W-1:0] digit_char;
        logic              last_digit;
    } digit_word_t;

    class digit_ledger;
        logic [RADIX_W-1:0] radix_setting;
        digit_word_t        pending_digits[$];
        int                 mismatches;

        function new();
            radix_setting = RADIX_RESET;
            mismatches = 0;
        endfunction

        task report(input string what);
            $display("[%0t] mismatch: %s", $time, what);
            mismatches++;
        endtask

        // digits of one accepted number, most significant first
        function void note_number(input logic [VALUE_BITS-1:0] value);
            logic [VALUE_BITS-1:0] quotient;
            logic [VALUE_BITS-1:0] divisor;
            logic [RADIX_W-1:0]    rems[$];
            logic [RADIX_W-1:0]    d;
            digit_word_t           w;
            quotient = value;
            if (radix_setting < RADIX_MIN)
                divisor = VALUE_BITS'(RADIX_MIN);
            else if (radix_setting > RADIX_MAX)
                divisor = VALUE_BITS'(RADIX_MAX);
            else
                divisor = VALUE_BITS'(radix_setting);
            if (quotient == '0)
                rems.push_back('0);
            else
            begin
                while (quotient != '0 && rems.size() < DIGIT_LIMIT)
                begin
                    rems.push_back(RADIX_W'(quotient % divisor));
                    quotient = quotient / divisor;
                end
            end
            for (int k = rems.size() - 1; k >= 0; k--)
            begin
                d = rems[k];
                if (d < 10)
                    w.digit_char = CHAR_W'(int'(d) + 48);        // '0'..'9'
                else
                    w.digit_char = CHAR_W'(int'(d) - 10 + 65);   // 'A'..'Z'
                w.last_digit = (k == 0);
                pending_digits.push_back(w);
            end
        endfunction

        task check_digit(input logic [CHAR_W-1:0] ch, input logic last_flag);
            digit_word_t want;
            if (pending_digits.size() == 0)
            begin
                report($sformatf("unexpected word char=%0d last=%0b", ch, last_flag));
                return;
            end
            want = pending_digits.pop_front();
            if (ch !== want.digit_char)
                report($sformatf("digit_char %0d, want %0d", ch, want.digit_char));
            if (last_flag !== want.last_digit)
                report($sformatf("last_digit %0b, want %0b", last_flag, want.last_digit));
        endtask
    endclass

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_we;
    logic [RADIX_W-1:0] cfg_wdata;
    bit                 steady;
    bit                 hold_req;
    digit_ledger        sb = new();

    ibq_in_if  number_ch ();
    ibq_out_if digit_ch ();

    integer_to_base_q_digits dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .number    (number_ch),
        .digits    (digit_ch),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always #5 clk = ~clk;

    function automatic int draw_gap();
        return steady ? 0 : $urandom_range(0, 14);
    endfunction

    function automatic logic [VALUE_BITS-1:0] random_value();
        logic [63:0] raw;
        int          width;
        raw = {$urandom, $urandom};
        width = $urandom_range(1, VALUE_BITS);
        case ($urandom_range(0, 19))
            0: return '0;
            1: return '1;
            default: return VALUE_BITS'(raw & ((64'd1 << width) - 64'd1));
        endcase
    endfunction

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_number(input logic [VALUE_BITS-1:0] v);
        int gap;
        gap = draw_gap();
        if (gap > 0)
        begin
            number_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        number_ch.valid <= 1'b1;
        number_ch.value <= v;
        @(posedge clk);
        while (!number_ch.ready)
            @(posedge clk);
        sb.note_number(v);
        @(negedge clk);
    endtask

    task automatic program_radix(input logic [RADIX_W-1:0] r);
        number_ch.valid <= 1'b0;
        while (sb.pending_digits.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= r;
        @(negedge clk);
        cfg_we <= 1'b0;
        sb.radix_setting = r;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && digit_ch.valid && digit_ch.ready)
            sb.check_digit(digit_ch.digit_char, digit_ch.last_digit);
    end

    // digit word receiver
    initial
    begin
        int gap;
        digit_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                digit_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            gap = draw_gap();
            if (gap > 0)
            begin
                digit_ch.ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            digit_ch.ready <= 1'b1;
            @(posedge clk);
            while (!digit_ch.valid)
                @(posedge clk);
        end
    end

    initial
    begin
        logic [RADIX_W-1:0] sweep_radix [9];
        number_ch.valid <= 1'b0;
        number_ch.value <= '0;
        cfg_we          <= 1'b0;
        cfg_wdata       <= '0;
        steady   = 1'b0;
        hold_req = 1'b0;
        sweep_radix = '{6'd2, 6'd36, 6'd16, 6'd3, 6'd0, 6'd63, 6'd10, 6'd1,
                        RADIX_W'($urandom_range(0, 63))};
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // radix left at its reset value
        send_number('0);
        send_number(63'd1);
        send_number(63'd9);
        send_number(63'd10);
        send_number('1);
        send_number(63'd1 << 62);
        send_number(63'd1000000000000000000);
        program_radix(6'd2);
        send_number('0);
        send_number(63'd1);
        send_number(63'd2);
        send_number('1);
        program_radix(6'd36);
        send_number(63'd35);
        send_number(63'd36);
        send_number(63'd1295);
        send_number('1);
        program_radix(6'd16);
        send_number(63'h0123_4567_89AB_CDEF);
        // out-of-range radix values saturate
        program_radix(6'd0);
        send_number(63'd5);
        send_number('1);
        program_radix(6'd63);
        send_number(63'd71);
        send_number('1);
        program_radix(6'd1);
        send_number(63'd3);
        program_radix(6'd37);
        send_number('0);

        for (int p = 0; p < 9; p++)
        begin
            program_radix(sweep_radix[p]);
            steady = (p == 0) || ($urandom_range(0, 3) == 0);
            if (p == 1)
                hold_req = 1'b1;
            for (int i = 0; i < 13; i++)
                send_number(random_value());
        end

        number_ch.valid <= 1'b0;
        while (sb.pending_digits.size() != 0)
            @(negedge clk);
        repeat (100) @(negedge clk);
        if (sb.mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        #60_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule

// ----- integer_to_base_q_digits.f -----
+incdir+hdl
hdl/ibq_pkg.sv
hdl/ibq_if.sv
hdl/ibq_ram.sv
hdl/ibq_div.sv
hdl/integer_to_base_q_digits.sv
verif/tb_top.sv
